[rtl/core/pse_pkg.sv]
package pse_pkg;

    localparam int MAX_VALUE = 65535;
    localparam int DEPTH     = MAX_VALUE + 1;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int VAL_W     = 16;
    localparam int CMP_W     = (CNT_W > VAL_W) ? CNT_W : VAL_W;

    localparam logic [VAL_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_RANGE   = 2'd1,
        STS_UNBUILT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_TEST,
        ST_MARK,
        ST_QUERY
    } t_state;

    typedef struct packed {
        logic accept;
        logic cfg_write;
        logic fill_step;
        logic test_read;
        logic mark_init;
        logic mark_step;
        logic next_i;
        logic load_query;
        logic load_build;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic sq_over;
        logic j_over;
        logic map_bit;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/prime_sieve_engine.sv]
// channel  | direction | handshake                | payload
// in       | input     | i_in_valid / o_in_stall  | i_op, i_value
// out      | output    | o_out_valid / i_out_stall| o_is_prime, o_status
// cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (limit)
//
// Query: taken in IDLE, its map bit is read and the result registered from QUERY; no new
// item is taken until the state is back in IDLE. Build: FILL writes every map address up to
// the limit; for each i with i*i <= limit, CHECK and TEST read its bit, and for a prime i
// MARK clears each multiple from i*i up; a last CHECK ends it. Map: one bit, registered read.
// Reset is synchronous, active low; the map holds no reset, while the built flag, the
// state and the output valid clear and the limit resets to 16'hFFFF.
// A result waits in the output register under stall; the next item is taken in the cycle
// that the waiting result is taken.
module prime_sieve_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_prime,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    pse_pkg::t_cmd cmd;
    pse_pkg::t_sts sts;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    pse_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_is_prime  (o_is_prime),
        .o_status    (o_status)
    );

endmodule

[rtl/core/pse_ctrl.sv]
module pse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    input  logic          i_cfg_valid,
    input  pse_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_cfg_ready,
    output pse_pkg::t_cmd o_cmd
);

    pse_pkg::t_state r_state;
    pse_pkg::t_state n_state;
    logic            in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == pse_pkg::OP_BUILD) begin
                        n_state = pse_pkg::ST_FILL;
                    end else begin
                        n_state = pse_pkg::ST_QUERY;
                    end
                end
            end
            pse_pkg::ST_FILL: begin
                if (i_sts.fill_last) begin
                    n_state = pse_pkg::ST_CHECK;
                end
            end
            pse_pkg::ST_CHECK: begin
                if (i_sts.sq_over) begin
                    n_state = pse_pkg::ST_IDLE;
                end else begin
                    n_state = pse_pkg::ST_TEST;
                end
            end
            pse_pkg::ST_TEST: begin
                if (i_sts.map_bit) begin
                    n_state = pse_pkg::ST_MARK;
                end else begin
                    n_state = pse_pkg::ST_CHECK;
                end
            end
            pse_pkg::ST_MARK: begin
                if (i_sts.j_over) begin
                    n_state = pse_pkg::ST_CHECK;
                end
            end
            pse_pkg::ST_QUERY: begin
                n_state = pse_pkg::ST_IDLE;
            end
            default: begin
                n_state = pse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            pse_pkg::ST_IDLE: begin
                o_in_stall      = !i_sts.out_free;
                o_cfg_ready     = 1'b1;
                o_cmd.accept    = i_in_valid && i_sts.out_free;
                o_cmd.cfg_write = i_cfg_valid;
            end
            pse_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            pse_pkg::ST_CHECK: begin
                o_cmd.load_build = i_sts.sq_over;
                o_cmd.test_read  = !i_sts.sq_over;
            end
            pse_pkg::ST_TEST: begin
                o_cmd.mark_init = i_sts.map_bit;
                o_cmd.next_i    = !i_sts.map_bit;
            end
            pse_pkg::ST_MARK: begin
                o_cmd.next_i    = i_sts.j_over;
                o_cmd.mark_step = !i_sts.j_over;
            end
            pse_pkg::ST_QUERY: begin
                o_cmd.load_query = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/pse_datapath.sv]
module pse_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pse_pkg::t_cmd            i_cmd,
    input  logic [pse_pkg::VAL_W-1:0] i_value,
    input  logic [pse_pkg::VAL_W-1:0] i_cfg_data,
    input  logic                     i_out_stall,
    output pse_pkg::t_sts            o_sts,
    output logic                     o_out_valid,
    output logic                     o_is_prime,
    output logic [1:0]               o_status
);

    logic [pse_pkg::VAL_W-1:0]  r_limit;
    logic                       r_built;
    logic                       r_out_valid;
    logic                       r_is_prime;
    pse_pkg::t_status           r_status;
    pse_pkg::t_status           r_qstatus;
    pse_pkg::t_status           n_qstatus;
    logic [pse_pkg::CNT_W-1:0]  r_fa;
    logic [pse_pkg::CNT_W-1:0]  r_i;
    logic [pse_pkg::CNT_W-1:0]  r_sq;
    logic [pse_pkg::CNT_W-1:0]  r_j;
    logic [pse_pkg::CNT_W-1:0]  n_fa;
    logic [pse_pkg::CNT_W-1:0]  n_i;
    logic [pse_pkg::CNT_W-1:0]  n_sq;
    logic [pse_pkg::CNT_W-1:0]  n_j;
    logic                       r_map [0:pse_pkg::DEPTH-1];
    logic                       r_rdata;

    logic [pse_pkg::CMP_W-1:0]  lim_wide;
    logic [pse_pkg::CMP_W-1:0]  eff_wide;
    logic [pse_pkg::CMP_W-1:0]  val_wide;
    logic [pse_pkg::CNT_W-1:0]  eff;
    logic                       we;
    logic [pse_pkg::ADDR_W-1:0] wa;
    logic                       wd;
    logic                       re;
    logic [pse_pkg::ADDR_W-1:0] ra;
    logic                       drained;

    assign lim_wide = pse_pkg::CMP_W'(r_limit);
    assign val_wide = pse_pkg::CMP_W'(i_value);

    always_comb begin
        if (lim_wide == '0) begin
            eff_wide = pse_pkg::CMP_W'(1);
        end else if (lim_wide > pse_pkg::CMP_W'(pse_pkg::MAX_VALUE)) begin
            eff_wide = pse_pkg::CMP_W'(pse_pkg::MAX_VALUE);
        end else begin
            eff_wide = lim_wide;
        end
    end

    assign eff = eff_wide[pse_pkg::CNT_W-1:0];

    always_comb begin
        if (!r_built) begin
            n_qstatus = pse_pkg::STS_UNBUILT;
        end else if (val_wide > eff_wide) begin
            n_qstatus = pse_pkg::STS_RANGE;
        end else begin
            n_qstatus = pse_pkg::STS_OK;
        end
    end

    always_comb begin
        n_fa = r_fa;
        n_i  = r_i;
        n_sq = r_sq;
        n_j  = r_j;
        if (i_cmd.accept) begin
            n_fa = '0;
            n_i  = pse_pkg::CNT_W'(2);
            n_sq = pse_pkg::CNT_W'(4);
        end
        if (i_cmd.fill_step) begin
            n_fa = r_fa + 1'b1;
        end
        if (i_cmd.next_i) begin
            n_i  = r_i + 1'b1;
            n_sq = r_sq + {r_i[pse_pkg::CNT_W-2:0], 1'b1};
        end
        if (i_cmd.mark_init) begin
            n_j = r_sq;
        end
        if (i_cmd.mark_step) begin
            n_j = r_j + r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa <= n_fa;
        r_i  <= n_i;
        r_sq <= n_sq;
        r_j  <= n_j;
        if (i_cmd.accept) begin
            r_qstatus <= n_qstatus;
        end
    end

    assign we = i_cmd.fill_step || i_cmd.mark_step;
    assign wa = i_cmd.fill_step ? r_fa[pse_pkg::ADDR_W-1:0] : r_j[pse_pkg::ADDR_W-1:0];
    assign wd = i_cmd.fill_step && (r_fa >= pse_pkg::CNT_W'(2));
    assign re = i_cmd.accept || i_cmd.test_read;
    assign ra = i_cmd.accept ? val_wide[pse_pkg::ADDR_W-1:0] : r_i[pse_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_map[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rdata <= r_map[ra];
        end
    end

    assign drained = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= pse_pkg::LIMIT_RESET;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_limit <= i_cfg_data;
                r_built <= 1'b0;
            end else if (i_cmd.load_build) begin
                r_built <= 1'b1;
            end
            if (i_cmd.load_query || i_cmd.load_build) begin
                r_out_valid <= 1'b1;
            end else if (drained) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_is_prime <= (r_qstatus == pse_pkg::STS_OK) && r_rdata;
            r_status   <= r_qstatus;
        end else if (i_cmd.load_build) begin
            r_is_prime <= 1'b0;
            r_status   <= pse_pkg::STS_OK;
        end
    end

    assign o_sts.fill_last = (r_fa == eff);
    assign o_sts.sq_over   = (r_sq > eff);
    assign o_sts.j_over    = (r_j > eff);
    assign o_sts.map_bit   = r_rdata;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_is_prime;
    assign o_status    = r_status;

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_step |-> (r_j >= pse_pkg::CNT_W'(4) && r_j <= eff))
        else $error("sieve clear outside 4..limit");

    a_build_sets_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_build |=> r_built)
        else $error("built flag not set after build");

    a_cfg_clears_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cfg_write |=> !r_built)
        else $error("built flag survived a limit write");

    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next_i |-> (r_sq == pse_pkg::CNT_W'(r_i * r_i)))
        else $error("square register out of step with candidate");

endmodule

[tb/prime_sieve_checker.sv]
module prime_sieve_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        i_op,
    input  logic [15:0] i_value,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_is_prime,
    input  logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             is_prime;
        pse_pkg::t_status status;
    } t_sieve_answer;

    bit            sieve_map [0:pse_pkg::DEPTH-1];
    bit            map_built;
    logic [15:0]   sieve_limit;
    t_sieve_answer answer_q[$];
    t_sieve_answer want;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        map_built   = 1'b0;
        sieve_limit = pse_pkg::LIMIT_RESET;
    end

    function automatic int eff_limit();
        if (sieve_limit == 16'd0) begin
            return 1;
        end
        if (int'(sieve_limit) > pse_pkg::MAX_VALUE) begin
            return pse_pkg::MAX_VALUE;
        end
        return int'(sieve_limit);
    endfunction

    function automatic void rebuild_sieve();
        int top_v;
        int p;
        int m;
        top_v = eff_limit();
        for (m = 0; m <= top_v; m++) begin
            sieve_map[m] = 1'b1;
        end
        sieve_map[0] = 1'b0;
        sieve_map[1] = 1'b0;
        for (p = 2; p * p <= top_v; p++) begin
            if (sieve_map[p]) begin
                for (m = p * p; m <= top_v; m += p) begin
                    sieve_map[m] = 1'b0;
                end
            end
        end
        map_built = 1'b1;
    endfunction

    function automatic t_sieve_answer answer_for(pse_pkg::t_op op, logic [15:0] v);
        t_sieve_answer a;
        a.is_prime = 1'b0;
        a.status   = pse_pkg::STS_OK;
        if (op == pse_pkg::OP_BUILD) begin
            rebuild_sieve();
        end else if (!map_built) begin
            a.status = pse_pkg::STS_UNBUILT;
        end else if (int'(v) > eff_limit()) begin
            a.status = pse_pkg::STS_RANGE;
        end else begin
            a.is_prime = sieve_map[v];
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            map_built   = 1'b0;
            sieve_limit = pse_pkg::LIMIT_RESET;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                sieve_limit = i_cfg_data;
                map_built   = 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: expected no transaction, actual is_prime=%0b status=%0d",
                             $time, o_is_prime, o_status);
                    mismatches++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_is_prime !== want.is_prime) begin
                        $display("%0t: is_prime expected %0b actual %0b",
                                 $time, want.is_prime, o_is_prime);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                answer_q.push_back(answer_for(pse_pkg::t_op'(i_op), i_value));
            end
        end
        outstanding = answer_q.size();
    end

endmodule

[tb/prime_sieve_engine_tb.sv]
module prime_sieve_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int TARGET_TXNS = 450;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_op        = 1'b0;
    logic [15:0] i_value     = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_is_prime;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = 16'd0;

    int mismatches;
    int outstanding;
    int cycles       = 0;
    int burst_left   = 0;
    int txns_sent    = 0;
    int stall_pct    = 0;
    int hold_cycles  = 0;
    int cur_limit    = 65535;
    bit steady       = 1'b0;

    prime_sieve_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_prime  (o_is_prime),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    prime_sieve_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_prime  (o_is_prime),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold off for a counted stretch on request, otherwise stall at random
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_txn(input pse_pkg::t_op op, input logic [15:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        txns_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_limit = (w == 16'd0) ? 1 : int'(w);
    endtask

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 16'($urandom_range(0, cur_limit));
        end
        if (r == 6) begin
            return 16'((cur_limit < 65535) ? cur_limit + 1 : cur_limit);
        end
        if (r == 7) begin
            return 16'(cur_limit);
        end
        return 16'($urandom());
    endfunction

    initial begin
        int          phase;
        int          phase_txns;
        int          k;
        logic [15:0] w;
        bit          allow_build;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct = 30;
        send_txn(pse_pkg::OP_QUERY, 16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'hFFFF);
        write_limit(16'hFFFF);
        send_txn(pse_pkg::OP_BUILD, 16'hFFFF);
        send_txn(pse_pkg::OP_QUERY, 16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'd1);
        send_txn(pse_pkg::OP_QUERY, 16'd2);
        send_txn(pse_pkg::OP_QUERY, 16'd4);
        send_txn(pse_pkg::OP_QUERY, 16'd65521);
        send_txn(pse_pkg::OP_QUERY, 16'hFFFF);
        send_txn(pse_pkg::OP_QUERY, 16'd65519);
        write_limit(16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'd1);
        send_txn(pse_pkg::OP_BUILD, 16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'd1);
        send_txn(pse_pkg::OP_QUERY, 16'd2);
        write_limit(16'd1);
        send_txn(pse_pkg::OP_BUILD, 16'd0);
        send_txn(pse_pkg::OP_QUERY, 16'd1);
        send_txn(pse_pkg::OP_QUERY, 16'd2);
        send_txn(pse_pkg::OP_QUERY, 16'hFFFF);
        write_limit(16'd2);
        send_txn(pse_pkg::OP_BUILD, 16'h5A5A);
        send_txn(pse_pkg::OP_QUERY, 16'd2);
        send_txn(pse_pkg::OP_QUERY, 16'd3);

        phase = 0;
        while (txns_sent < TARGET_TXNS) begin
            case ($urandom_range(0, 19))
                0:       w = 16'd0;
                1:       w = 16'd1;
                2:       w = 16'd2;
                3:       w = 16'($urandom_range(1000, 3000));
                4:       w = 16'hFFFF;
                default: w = 16'($urandom_range(3, 400));
            endcase
            write_limit(w);
            allow_build = (cur_limit != 65535);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            phase_txns = $urandom_range(15, 40);
            if ($urandom_range(0, 3) == 0) begin
                send_txn(pse_pkg::OP_QUERY, pick_value());
            end
            if (allow_build) begin
                send_txn(pse_pkg::OP_BUILD, 16'($urandom()));
            end
            if (phase == 0) begin
                drain();
                hold_cycles = 300;
            end
            for (k = 0; k < phase_txns; k++) begin
                if (allow_build && $urandom_range(0, 19) == 0) begin
                    send_txn(pse_pkg::OP_BUILD, 16'($urandom()));
                end else begin
                    send_txn(pse_pkg::OP_QUERY, pick_value());
                end
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
